// ===== rtl/core/mma_pkg.sv =====
// ---------------------------------------------------------------------------
// mma_pkg: shared types and constants for the moving average block
// Holds phase encoding, item kinds and the job record passed front to back.
// ---------------------------------------------------------------------------
package mma_pkg;

	localparam int DEPTH_DEF    = 1024;
	localparam int CHANNELS_DEF = 16;
	localparam int SAMPLE_W     = 32;
	localparam int CNT_W        = 5;
	localparam int CH_W         = 4;
	localparam int SETS_W       = 11;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_CLOSE   = 2'd1,
		KIND_RESTART = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_WAITING  = 2'd0,
		PH_BUILDING = 2'd1,
		PH_PENDING  = 2'd2,
		PH_CLOSED   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_READ = 2'd1,
		BK_SUM  = 2'd2,
		BK_DIV  = 2'd3
	} back_state_t;

	// work request from the front part to the back part
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     ch;
		logic                last;
		logic                closed;
		logic [SETS_W-1:0]   sets;
	} job_t;

endpackage

// ===== rtl/core/mma_if.sv =====
// ---------------------------------------------------------------------------
// mma_stream_if: valid/ready channel
// Carries one payload of configurable type between source and sink.
// ---------------------------------------------------------------------------
interface mma_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mma_front.sv =====
// ---------------------------------------------------------------------------
// mma_front: request classifier
// Tracks phase, set position, window length and oldest slot; emits jobs.
// ---------------------------------------------------------------------------
module mma_front
	import mma_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int SLOT_W   = $clog2(DEPTH)
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    count_q,
	input  logic                idle,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_kind,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                job_valid,
	input  logic                job_ready,
	output job_t                job,
	output logic [SLOT_W-1:0]   job_slot,
	output logic                clear
);
	localparam int CHS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	phase_t            phase_q;
	logic [SETS_W-1:0] sets_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [CHS_W-1:0]  pos_q;

	logic [CNT_W-1:0]  cnt;
	logic              last;
	logic [SETS_W-1:0] sets_n;
	logic              fire;
	logic              full_n;

	// clamp channel count into 1..CHANNELS
	always_comb begin
		cnt = count_q;
		if (cnt == '0)
			cnt = CNT_W'(1);
		if (32'(cnt) > CHANNELS)
			cnt = CNT_W'(CHANNELS);
	end

	assign last = (32'(pos_q) + 1 >= 32'(cnt));
	assign sets_n = ((pos_q == '0) && (32'(sets_q) < DEPTH)) ? sets_q + 1'b1 : sets_q;
	assign full_n = (32'(sets_n) >= DEPTH);

	// samples need queue room; restart waits until no sample is in flight
	assign in_ready = (kind_t'(in_kind) == KIND_SAMPLE) ? job_ready
		: (kind_t'(in_kind) == KIND_RESTART) ? idle : 1'b1;
	assign fire = in_valid && in_ready;
	assign job_valid = in_valid && (kind_t'(in_kind) == KIND_SAMPLE);
	assign clear = fire && (kind_t'(in_kind) == KIND_RESTART);

	// build the job
	always_comb begin
		job.sample = in_sample;
		job.ch     = CH_W'(pos_q);
		job.last   = last;
		job.closed = (phase_q == PH_CLOSED);
		job.sets   = (phase_q == PH_CLOSED) ? sets_q : sets_n;
		if (phase_q == PH_CLOSED)
			job_slot = oldest_q;
		else
			job_slot = (sets_n == '0) ? '0 : SLOT_W'(sets_n - 1'b1);
	end

	// advance window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAITING;
			sets_q   <= '0;
			oldest_q <= '0;
			pos_q    <= '0;
		end else if (fire) begin
			case (kind_t'(in_kind))
				KIND_RESTART: begin
					phase_q  <= PH_WAITING;
					sets_q   <= '0;
					oldest_q <= '0;
					pos_q    <= '0;
				end
				KIND_CLOSE: begin
					if (phase_q == PH_BUILDING)
						phase_q <= (pos_q == '0) ? PH_CLOSED : PH_PENDING;
				end
				KIND_SAMPLE: begin
					if (phase_q != PH_CLOSED)
						sets_q <= sets_n;
					if (last) begin
						pos_q <= '0;
						if (phase_q == PH_CLOSED) begin
							oldest_q <= (32'(oldest_q) + 1 >= 32'(sets_q)) ? '0
								: oldest_q + 1'b1;
						end else if (phase_q == PH_PENDING || full_n) begin
							phase_q  <= PH_CLOSED;
							oldest_q <= '0;
						end else begin
							phase_q <= PH_BUILDING;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
						if (phase_q == PH_WAITING)
							phase_q <= PH_BUILDING;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/mma_queue.sv =====
// ---------------------------------------------------------------------------
// mma_queue: two-entry job queue
// Decouples the classifier from the arithmetic back part.
// ---------------------------------------------------------------------------
module mma_queue
	import mma_pkg::*;
#(
	parameter int SLOT_W = 10
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  job_t              wr_job,
	input  logic [SLOT_W-1:0] wr_slot,
	output logic              rd_valid,
	input  logic              rd_ready,
	output job_t              rd_job,
	output logic [SLOT_W-1:0] rd_slot
);
	job_t              job_q [2];
	logic [SLOT_W-1:0] slot_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        fill_q;
	logic              push, pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;
	assign rd_job  = job_q[rp_q];
	assign rd_slot = slot_q[rp_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wp_q]  <= wr_job;
			slot_q[wp_q] <= wr_slot;
		end
	end

	// advance pointers; restart is taken only with no sample in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	logic unused_clear;
	assign unused_clear = clear;
endmodule

// ===== rtl/core/mma_back.sv =====
// ---------------------------------------------------------------------------
// mma_back: window store, running sums and serial divider
// Reads the oldest sample, updates the sum, then divides by window length.
// ---------------------------------------------------------------------------
module mma_back
	import mma_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int SLOT_W   = $clog2(DEPTH)
)(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              job_valid,
	output logic              job_ready,
	input  job_t              job,
	input  logic [SLOT_W-1:0] job_slot,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [31:0]       res_mean,
	output logic [CH_W-1:0]   res_ch,
	output logic              res_last,
	output logic [SETS_W-1:0] res_sets
);
	localparam int CHS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SUM_W = SAMPLE_W + SLOT_W + 1;
	localparam int ADR_W = SLOT_W + CHS_W;
	localparam int DCNT_W = $clog2(SUM_W + 1);

	logic [SAMPLE_W-1:0] mem [DEPTH * CHANNELS];
	logic signed [SUM_W-1:0] sums_q [CHANNELS];

	back_state_t         st_q, st_n;
	job_t                job_q;
	logic [ADR_W-1:0]    adr_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [SUM_W-1:0]    quo_q, rem_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                neg_q;
	logic                out_full_q;
	logic [CHS_W-1:0]    chi;
	logic signed [SUM_W-1:0] new_sum;
	logic [SUM_W:0]      trial;
	logic [SUM_W-1:0]    rem_sh;

	assign chi = CHS_W'(job_q.ch);
	assign job_ready = (st_q == BK_IDLE);
	assign res_valid = out_full_q;

	// sum update: add new sample, drop oldest when window is closed
	always_comb begin
		new_sum = sums_q[chi] + SUM_W'(signed'(job_q.sample));
		if (job_q.closed)
			new_sum = new_sum - SUM_W'(signed'(old_q));
	end

	// one quotient bit per cycle, magnitude restoring divide
	assign rem_sh = {rem_q[SUM_W-2:0], quo_q[SUM_W-1]};
	assign trial = {1'b0, rem_sh} - (SUM_W+1)'(job_q.sets);

	always_comb begin
		st_n = st_q;
		case (st_q)
			BK_IDLE: if (job_valid) st_n = BK_READ;
			BK_READ: st_n = BK_SUM;
			BK_SUM:  st_n = BK_DIV;
			BK_DIV:  if (cnt_q == '0 && !out_full_q) st_n = BK_IDLE;
			default: st_n = BK_IDLE;
		endcase
	end

	// registered read of the oldest sample, then overwrite it
	always_ff @(posedge clk) begin
		if (st_q == BK_SUM)
			mem[adr_q] <= job_q.sample;
		if (st_q == BK_READ)
			old_q <= mem[adr_q];
		if (st_q == BK_IDLE && job_valid) begin
			job_q <= job;
			adr_q <= {job_slot, CHS_W'(job.ch)};
		end
	end

	// sums, divider and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BK_IDLE;
			out_full_q <= 1'b0;
			cnt_q      <= '0;
			for (int i = 0; i < CHANNELS; i++)
				sums_q[i] <= '0;
		end else begin
			st_q <= st_n;
			if (out_full_q && res_ready)
				out_full_q <= 1'b0;
			if (clear) begin
				for (int i = 0; i < CHANNELS; i++)
					sums_q[i] <= '0;
			end
			case (st_q)
				BK_READ: begin
				end
				BK_SUM: begin
					sums_q[chi] <= new_sum;
					neg_q <= new_sum[SUM_W-1];
					quo_q <= new_sum[SUM_W-1] ? -new_sum : new_sum;
					rem_q <= '0;
					cnt_q <= DCNT_W'(SUM_W);
				end
				BK_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
						if (!trial[SUM_W]) begin
							rem_q <= trial[SUM_W-1:0];
							quo_q <= {quo_q[SUM_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_sh;
							quo_q <= {quo_q[SUM_W-2:0], 1'b0};
						end
					end else if (!out_full_q) begin
						out_full_q <= 1'b1;
						res_mean   <= neg_q ? 32'(-quo_q) : quo_q[31:0];
						res_ch     <= job_q.ch;
						res_last   <= job_q.last;
						res_sets   <= job_q.sets;
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== rtl/core/multichannel_moving_average_top.sv =====
// A sample request passes the front classifier and the job queue; the back part
// then reads the oldest sample, updates the sum and divides bit-serially. It takes
// a new job only once it is done with the last, and a result left waiting at the
// output holds the back part until it is taken. Window-closed requests are always
// accepted; restart waits until no sample is in flight. Neither gives a result.
// arst_n clears control state and running sums; the window store is not cleared.
// ---------------------------------------------------------------------------
// multichannel_moving_average_top: moving window mean over channel sets
// Front classifier, job queue and arithmetic back part.
// ---------------------------------------------------------------------------
module multichannel_moving_average_top
	import mma_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int CHANNELS = CHANNELS_DEF
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	mma_stream_if.sink       in_ch,
	mma_stream_if.source     out_ch
);
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CNT_W-1:0]  count_q;
	logic              fj_valid, fj_ready, qj_valid, qj_ready, clear;
	job_t              fj, qj;
	logic [SLOT_W-1:0] fslot, qslot;
	logic              in_rdy_f;
	logic              back_idle;

	// channel count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= CNT_W'(1);
		else if (cfg_we)
			count_q <= cfg_wdata;
	end

	assign in_ch.ready = in_rdy_f;

	// nothing queued and the back part waiting for a job
	assign back_idle = qj_ready && !qj_valid;

	mma_front #(.DEPTH(DEPTH), .CHANNELS(CHANNELS), .SLOT_W(SLOT_W)) u_front (
		.clk, .arst_n, .count_q, .idle(back_idle),
		.in_valid(in_ch.valid), .in_ready(in_rdy_f),
		.in_kind(in_ch.data.kind), .in_sample(in_ch.data.sample_value),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj), .job_slot(fslot),
		.clear
	);

	mma_queue #(.SLOT_W(SLOT_W)) u_queue (
		.clk, .arst_n, .clear,
		.wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj), .wr_slot(fslot),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj), .rd_slot(qslot)
	);

	mma_back #(.DEPTH(DEPTH), .CHANNELS(CHANNELS), .SLOT_W(SLOT_W)) u_back (
		.clk, .arst_n, .clear,
		.job_valid(qj_valid), .job_ready(qj_ready), .job(qj), .job_slot(qslot),
		.res_valid(out_ch.valid), .res_ready(out_ch.ready),
		.res_mean(out_ch.data.mean_value), .res_ch(out_ch.data.channel_index),
		.res_last(out_ch.data.last_of_set), .res_sets(out_ch.data.window_sets)
	);
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for multichannel_moving_average_top
// Drives sample, window-closed and restart requests with random gaps and
// random output stalls. A local predictor of the windowed channel means
// checks every result field by field, in order.
// ---------------------------------------------------------------------------
module tb;
	import mma_pkg::*;

	localparam int DEPTH    = DEPTH_DEF;
	localparam int CHANNELS = CHANNELS_DEF;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 150;

	typedef struct packed {
		kind_t               kind;
		logic [SAMPLE_W-1:0] sample_value;
	} sample_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean_value;
		logic [CH_W-1:0]     channel_index;
		logic                last_of_set;
		logic [SETS_W-1:0]   window_sets;
	} mean_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	mma_stream_if #(.payload_t(sample_req_t)) in_ch ();
	mma_stream_if #(.payload_t(mean_rsp_t)) out_ch ();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	multichannel_moving_average_top #(.DEPTH(DEPTH), .CHANNELS(CHANNELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [SAMPLE_W-1:0] win_mem [DEPTH*CHANNELS];
	longint ch_sum [CHANNELS];
	phase_t win_phase;
	int unsigned sets_in_win;
	int unsigned oldest_set;
	int unsigned ch_pos;
	logic [CNT_W-1:0] count_reg;

	mean_rsp_t expected_means[$];
	int errors = 0;
	int items_sent = 0;
	int means_checked = 0;
	int sets_closed = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	function automatic void clear_window();
		foreach (ch_sum[i]) ch_sum[i] = 0;
		win_phase = PH_WAITING;
		sets_in_win = 0;
		oldest_set = 0;
		ch_pos = 0;
	endfunction

	// expected mean for one accepted sample
	function automatic mean_rsp_t predict_mean(logic [SAMPLE_W-1:0] s);
		int unsigned cnt, ch, slot;
		bit last;
		longint v;
		mean_rsp_t r;
		cnt = count_reg;
		if (cnt == 0) cnt = 1;
		if (cnt > CHANNELS) cnt = CHANNELS;
		ch = (ch_pos >= CHANNELS) ? CHANNELS - 1 : ch_pos;
		last = (ch + 1 >= cnt);
		v = longint'($signed(s));
		if (win_phase == PH_CLOSED) begin
			slot = (oldest_set >= DEPTH) ? 0 : oldest_set;
			ch_sum[ch] -= longint'($signed(win_mem[slot*CHANNELS + ch]));
		end else begin
			if (win_phase == PH_WAITING) win_phase = PH_BUILDING;
			if (ch == 0 && sets_in_win < DEPTH) sets_in_win++;
			slot = (sets_in_win == 0) ? 0 : sets_in_win - 1;
		end
		win_mem[slot*CHANNELS + ch] = s;
		ch_sum[ch] += v;
		r.mean_value = SAMPLE_W'(ch_sum[ch] / longint'((sets_in_win == 0) ? 1 : sets_in_win));
		r.channel_index = CH_W'(ch);
		r.last_of_set = last;
		r.window_sets = SETS_W'(sets_in_win);
		if (last) begin
			ch_pos = 0;
			if (win_phase == PH_CLOSED) begin
				oldest_set = (oldest_set + 1 >= sets_in_win) ? 0 : oldest_set + 1;
			end else if (win_phase == PH_PENDING || sets_in_win >= DEPTH) begin
				win_phase = PH_CLOSED;
				oldest_set = 0;
				sets_closed++;
			end
		end else begin
			ch_pos = ch + 1;
		end
		return r;
	endfunction

	function automatic void predict_request(sample_req_t req);
		case (req.kind)
			KIND_SAMPLE: expected_means.push_back(predict_mean(req.sample_value));
			KIND_RESTART: clear_window();
			KIND_CLOSE: begin
				if (win_phase == PH_BUILDING) begin
					win_phase = (ch_pos == 0) ? PH_CLOSED : PH_PENDING;
					if (ch_pos == 0) sets_closed++;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return SAMPLE_W'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	// send one request and predict it at acceptance
	task automatic send_req(kind_t k, logic [SAMPLE_W-1:0] s);
		int gap;
		sample_req_t req;
		gap = pick_gap();
		req.kind = k;
		req.sample_value = s;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= req;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_request(req);
		items_sent++;
	endtask

	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		send_req(KIND_SAMPLE, s);
	endtask

	// hold until every expected mean has arrived and the block settles
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [CNT_W-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		count_reg = v;
	endtask

	task automatic restart_with_count(logic [CNT_W-1:0] v);
		send_req(KIND_RESTART, '0);
		write_count(v);
	endtask

	task automatic test_directed_extremes();
		send_req(KIND_CLOSE, '0);
		send_req(KIND_NONE, 32'hFFFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		send_req(KIND_CLOSE, '0);
		send_req(KIND_CLOSE, '0);
		send_sample(32'h8000_0000);
		send_sample(32'hFFFF_FFF9);
		send_req(KIND_NONE, 32'h1234_5678);
		send_sample(32'h0000_0007);
	endtask

	task automatic test_count_range();
		// zero acts as one channel, oversize acts as all channels
		restart_with_count(5'd0);
		send_sample(32'd10);
		send_sample(32'hFFFF_FFF5);
		restart_with_count(5'd31);
		for (int i = 0; i < CHANNELS + 2; i++) send_sample(pick_sample());
		restart_with_count(5'd17);
		for (int i = 0; i < CHANNELS; i++) send_sample(pick_sample());
	endtask

	task automatic test_mid_set_changes();
		// lower the count mid-set: the next element ends the set
		restart_with_count(5'd4);
		send_sample(32'd100);
		send_sample(32'd200);
		write_count(5'd1);
		send_sample(32'd300);
		send_sample(32'd5);
		// close mid-set: set finishes as build-up, then the window closes
		restart_with_count(5'd3);
		for (int i = 0; i < 4; i++) send_sample(pick_sample());
		send_req(KIND_CLOSE, '0);
		for (int i = 0; i < 2 + 9; i++) send_sample(pick_sample());
		send_req(KIND_CLOSE, '0);
		send_sample(32'd1);
	endtask

	task automatic test_auto_close();
		// build up to the full window with no close request
		quiet = 1'b1;
		restart_with_count(5'd1);
		for (int i = 0; i < DEPTH + 8; i++) send_sample(pick_sample());
		quiet = 1'b0;
	endtask

	task automatic test_random_windows();
		int n_build, n_closed, cnt;
		int start_items;
		start_items = items_sent;
		while (items_sent - start_items < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 7))
				0: cnt = $urandom_range(0, 31);
				1: cnt = 16;
				default: cnt = $urandom_range(1, 6);
			endcase
			restart_with_count(CNT_W'(cnt));
			if (cnt == 0) cnt = 1;
			if (cnt > CHANNELS) cnt = CHANNELS;
			n_build = $urandom_range(1, 6);
			n_closed = $urandom_range(0, 8);
			for (int i = 0; i < n_build * cnt; i++) begin
				if (i == (n_build - 1) * cnt + 1 && $urandom_range(0, 2) == 0)
					send_req(KIND_CLOSE, '0);
				if ($urandom_range(0, 30) == 0) send_req(KIND_NONE, $urandom);
				send_sample(pick_sample());
			end
			send_req(KIND_CLOSE, '0);
			for (int i = 0; i < n_closed * cnt + $urandom_range(0, cnt - 1); i++) begin
				if ($urandom_range(0, 25) == 0)
					send_req(kind_t'($urandom_range(KIND_CLOSE, KIND_NONE)), $urandom);
				send_sample(pick_sample());
			end
			// now and then let the pipeline empty before the next request
			if ($urandom_range(0, 9) == 0) wait_drained();
		end
		quiet = 1'b0;
	endtask

	// output stalls: mostly short, a few long, none started while quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 9) < 3)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	// check each result against the oldest expected mean
	always @(posedge clk) begin
		mean_rsp_t exp_r, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_means.size() == 0) begin
				$error("unexpected result: mean %0d ch %0d",
					$signed(got.mean_value), got.channel_index);
				errors++;
			end else begin
				exp_r = expected_means.pop_front();
				means_checked++;
				if (got.mean_value !== exp_r.mean_value) begin
					$error("mean_value: expected %0d, got %0d",
						$signed(exp_r.mean_value), $signed(got.mean_value));
					errors++;
				end
				if (got.channel_index !== exp_r.channel_index) begin
					$error("channel_index: expected %0d, got %0d",
						exp_r.channel_index, got.channel_index);
					errors++;
				end
				if (got.last_of_set !== exp_r.last_of_set) begin
					$error("last_of_set: expected %0d, got %0d",
						exp_r.last_of_set, got.last_of_set);
					errors++;
				end
				if (got.window_sets !== exp_r.window_sets) begin
					$error("window_sets: expected %0d, got %0d",
						exp_r.window_sets, got.window_sets);
					errors++;
				end
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clear_window();
		count_reg = 5'd1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_count_range();
		test_mid_set_changes();
		test_auto_close();
		test_random_windows();
		wait_drained();
		if (expected_means.size() != 0) begin
			$error("%0d expected means never arrived", expected_means.size());
			errors++;
		end
		$display("tb: %0d requests sent, %0d means checked, %0d windows closed",
			items_sent, means_checked, sets_closed);
		$display("tb: covered count range, mid-set changes, auto close and random windows");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/mma_pkg.sv
rtl/core/mma_if.sv
rtl/core/mma_front.sv
rtl/core/mma_queue.sv
rtl/core/mma_back.sv
rtl/core/multichannel_moving_average_top.sv
sim/tb.sv
